>>> rtl/gpll_pkg.sv
// Package for the grid PLL timer loop: widths, reset values, microcode and shared types.
`timescale 1ns / 1ps

package gpll_pkg;

	// Field and format widths
	localparam int SAMPLE_BITS    = 12;
	localparam int ERR_BITS       = SAMPLE_BITS + 1;
	localparam int FREQ_FRAC_BITS = 16;
	localparam int FREQ_BITS      = 6 + FREQ_FRAC_BITS;
	localparam int VOLT_FRAC_BITS = 10;
	localparam int GAIN_BITS      = 16;
	localparam int TIMER_BITS     = 16;
	localparam int CFG_IDX_BITS   = 3;
	localparam int CFG_DATA_BITS  = FREQ_BITS;

	// Datapath widths: one shared signed multiplier
	localparam int MUL_A_BITS = ERR_BITS + GAIN_BITS + 1;
	localparam int MUL_B_BITS = FREQ_BITS + 1;
	localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
	localparam int NUM_BITS   = PROD_BITS;
	localparam int MAG_BITS   = NUM_BITS - 2;
	localparam int DEN_BITS   = FREQ_BITS + VOLT_FRAC_BITS;
	localparam int DIV_CNT_BITS = $clog2(MAG_BITS);
	localparam int INC_BITS   = MUL_A_BITS - VOLT_FRAC_BITS;
	localparam int SUM_BITS   = FREQ_BITS + 2;

	// Timer clock, scaled by 2^(FREQ_FRAC_BITS-1) and by the volt scale
	localparam longint TIMER_CLOCK_HZ = 64'd16000000;
	localparam int CLK_SHIFT = FREQ_FRAC_BITS - 1 + VOLT_FRAC_BITS;
	localparam logic [NUM_BITS-1:0] CLK_SCALED = NUM_BITS'(TIMER_CLOCK_HZ << CLK_SHIFT);
	localparam logic [NUM_BITS-1:0] TIMER_OFFSET = NUM_BITS'(131070);
	localparam logic [NUM_BITS-1:0] TIMER_OFFSET_M1 = NUM_BITS'(131069);
	localparam logic [MUL_A_BITS-1:0] ROUND_HALF = MUL_A_BITS'(1) << (VOLT_FRAC_BITS - 1);

	// Register reset values
	localparam logic [FREQ_BITS-1:0]  RST_START_FREQ = FREQ_BITS'(3276800);
	localparam logic [GAIN_BITS-1:0]  RST_PROP_GAIN  = GAIN_BITS'(5000);
	localparam logic [GAIN_BITS-1:0]  RST_INTEG_GAIN = GAIN_BITS'(6554);
	localparam logic [FREQ_BITS-1:0]  RST_FREQ_MIN   = FREQ_BITS'(3080192);
	localparam logic [FREQ_BITS-1:0]  RST_FREQ_MAX   = FREQ_BITS'(3473408);
	localparam logic [TIMER_BITS-1:0] RST_TIMER_MIN  = TIMER_BITS'(19871);
	localparam logic [TIMER_BITS-1:0] RST_TIMER_MAX  = TIMER_BITS'(39140);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [ERR_BITS-1:0]    error_t;
	typedef logic [FREQ_BITS-1:0]          freq_t;
	typedef logic [TIMER_BITS-1:0]         timer_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_START_FREQ = 3'd0,
		CFG_PROP_GAIN  = 3'd1,
		CFG_INTEG_GAIN = 3'd2,
		CFG_FREQ_MIN   = 3'd3,
		CFG_FREQ_MAX   = 3'd4,
		CFG_TIMER_MIN  = 3'd5,
		CFG_TIMER_MAX  = 3'd6
	} cfg_idx_t;

	// Divider control from the sequencer
	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

	// Microcode: datapath operation, next-step condition, jump target
	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_MUL_PE,
		OP_MUL_PS,
		OP_NUM,
		OP_ABS,
		OP_DIV,
		OP_QOFF,
		OP_TCLAMP,
		OP_MUL_IE,
		OP_ROUND,
		OP_SUM,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		CND_NEXT,
		CND_WAIT_IN,
		CND_ZERO_SPD,
		CND_LOOP,
		CND_WAIT_OUT,
		CND_JUMP
	} cond_t;

	typedef logic [3:0] step_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	localparam step_t STEP_ACCEPT = 4'd0;
	localparam step_t STEP_MUL_PE = 4'd1;
	localparam step_t STEP_MUL_PS = 4'd2;
	localparam step_t STEP_NUM    = 4'd3;
	localparam step_t STEP_ABS    = 4'd4;
	localparam step_t STEP_DIV    = 4'd5;
	localparam step_t STEP_QOFF   = 4'd6;
	localparam step_t STEP_TCLAMP = 4'd7;
	localparam step_t STEP_MUL_IE = 4'd8;
	localparam step_t STEP_ROUND  = 4'd9;
	localparam step_t STEP_SUM    = 4'd10;
	localparam step_t STEP_EMIT   = 4'd11;

	// Control store: one word per step
	function automatic uword_t ucode(step_t step);
		uword_t w;
		unique case (step)
			STEP_ACCEPT: w = '{OP_ACCEPT, CND_WAIT_IN,  STEP_ACCEPT};
			STEP_MUL_PE: w = '{OP_MUL_PE, CND_NEXT,     STEP_ACCEPT};
			STEP_MUL_PS: w = '{OP_MUL_PS, CND_NEXT,     STEP_ACCEPT};
			STEP_NUM:    w = '{OP_NUM,    CND_ZERO_SPD, STEP_TCLAMP};
			STEP_ABS:    w = '{OP_ABS,    CND_NEXT,     STEP_ACCEPT};
			STEP_DIV:    w = '{OP_DIV,    CND_LOOP,     STEP_DIV};
			STEP_QOFF:   w = '{OP_QOFF,   CND_NEXT,     STEP_ACCEPT};
			STEP_TCLAMP: w = '{OP_TCLAMP, CND_NEXT,     STEP_ACCEPT};
			STEP_MUL_IE: w = '{OP_MUL_IE, CND_NEXT,     STEP_ACCEPT};
			STEP_ROUND:  w = '{OP_ROUND,  CND_NEXT,     STEP_ACCEPT};
			STEP_SUM:    w = '{OP_SUM,    CND_NEXT,     STEP_ACCEPT};
			STEP_EMIT:   w = '{OP_EMIT,   CND_WAIT_OUT, STEP_ACCEPT};
			default:     w = '{OP_NOP,    CND_JUMP,     STEP_ACCEPT};
		endcase
		return w;
	endfunction

endpackage

>>> rtl/gpll_if.sv
// Valid/ready channel interfaces for grid samples and loop results.
`timescale 1ns / 1ps

interface gpll_sample_if;
	logic              valid;
	logic              ready;
	gpll_pkg::sample_t grid_sample;

	modport source (output valid, output grid_sample, input ready);
	modport sink (input valid, input grid_sample, output ready);
endinterface

interface gpll_result_if;
	logic             valid;
	logic             ready;
	gpll_pkg::timer_t timer_reload;
	gpll_pkg::freq_t  loop_frequency;
	gpll_pkg::error_t phase_error;

	modport source (output valid, output timer_reload, output loop_frequency,
		output phase_error, input ready);
	modport sink (input valid, input timer_reload, input loop_frequency,
		input phase_error, output ready);
endinterface

>>> rtl/gpll_div.sv
// Restoring unsigned divider, one quotient bit per step.
`timescale 1ns / 1ps

module gpll_div (
	input  logic                                clk,
	input  gpll_pkg::div_ctrl_t                 ctrl,
	input  logic [gpll_pkg::MAG_BITS-1:0]       dividend,
	input  logic [gpll_pkg::DEN_BITS-1:0]       divisor,
	output logic [gpll_pkg::MAG_BITS-1:0]       quotient
);
	import gpll_pkg::*;

	logic [MAG_BITS-1:0] quot_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [DEN_BITS:0]   shifted;
	logic [DEN_BITS:0]   trial;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		shifted = {rem_q, quot_q[MAG_BITS-1]};
		trial   = shifted - {1'b0, divisor};
	end

	// Load the operands, then keep the remainder whenever it fits
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (ctrl.step) begin
			if (!trial[DEN_BITS]) begin
				rem_q  <= trial[DEN_BITS-1:0];
				quot_q <= {quot_q[MAG_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= shifted[DEN_BITS-1:0];
				quot_q <= {quot_q[MAG_BITS-2:0], 1'b0};
			end
		end
	end

	assign quotient = quot_q;

endmodule

>>> rtl/grid_pll_pi_timer_loop.sv
// Top level of the grid PLL: microcoded sequencer, shared datapath and result register.
`timescale 1ns / 1ps

// Grid phase-locked loop with a proportional-integral timer controller. Each request on
// sample_ch carries one signed grid voltage sample (two per grid period); each one yields
// exactly one request on result_ch with the clamped timer reload, the updated loop
// frequency (Q6.16 Hz) and the alternating phase error. A short microprogram runs the
// work on one shared 30x23 multiplier and a one-bit-per-cycle restoring divider that
// yields a 51-bit quotient; when the loop frequency is zero the division is skipped. A
// new sample is accepted only after the previous item has reached the result register.
// The result sits in an output register, so the next sample is taken while it waits; a
// new result waits for the previous one to be taken. Registers are written through
// cfg_wr_en/cfg_index/cfg_data; the user must write them only while no item is in
// flight, which the block itself does not enforce. A start_frequency write loads the
// loop frequency at once, and unknown indexes are ignored.
module grid_pll_pi_timer_loop (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [gpll_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [gpll_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	gpll_sample_if.sink                           sample_ch,
	gpll_result_if.source                         result_ch
);
	import gpll_pkg::*;

	// Configuration registers
	logic [GAIN_BITS-1:0] prop_gain_q;
	logic [GAIN_BITS-1:0] integ_gain_q;
	freq_t                freq_min_q;
	freq_t                freq_max_q;
	timer_t               timer_min_q;
	timer_t               timer_max_q;

	// Loop state
	sample_t prev_q;
	logic    odd_q;
	freq_t   loop_speed_q;

	// Sequencer
	step_t                   step_q;
	step_t                   step_d;
	uword_t                  uw;
	logic [DIV_CNT_BITS-1:0] cnt_q;

	// Datapath registers
	error_t                       err_q;
	logic signed [PROD_BITS-1:0]  prod_q;
	logic [NUM_BITS-1:0]          num_q;
	logic                         neg_q;
	logic                         zero_q;
	logic signed [NUM_BITS-1:0]   qoff_q;
	timer_t                       reload_q;
	logic [INC_BITS-1:0]          mag_q;
	logic                         inc_neg_q;
	logic signed [SUM_BITS-1:0]   sum_q;

	// Result register
	logic   out_valid_q;
	timer_t out_reload_q;
	freq_t  out_freq_q;
	error_t out_err_q;

	// Combinational datapath
	logic                         sample_acc;
	logic                         out_free;
	error_t                       cur_x;
	error_t                       prev_x;
	error_t                       err_new;
	logic signed [MUL_A_BITS-1:0] mul_a;
	logic signed [MUL_B_BITS-1:0] mul_b;
	logic signed [PROD_BITS-1:0]  product;
	logic [NUM_BITS-1:0]          num_abs;
	logic [MAG_BITS-1:0]          quotient;
	logic [NUM_BITS-1:0]          quot_x;
	logic [NUM_BITS-1:0]          qoff_lhs;
	logic [NUM_BITS-1:0]          qoff_sub;
	logic signed [NUM_BITS-1:0]   t_lo;
	logic signed [NUM_BITS-1:0]   t_hi;
	logic signed [NUM_BITS-1:0]   t_low_cl;
	logic signed [NUM_BITS-1:0]   t_cl;
	logic [MUL_A_BITS-1:0]        p_abs;
	logic [MUL_A_BITS-1:0]        p_rnd;
	logic signed [SUM_BITS-1:0]   inc_x;
	logic signed [SUM_BITS-1:0]   f_lo;
	logic signed [SUM_BITS-1:0]   f_hi;
	logic signed [SUM_BITS-1:0]   f_low_cl;
	logic signed [SUM_BITS-1:0]   f_cl;
	div_ctrl_t                    div_ctrl;

	assign uw         = ucode(step_q);
	assign sample_acc = sample_ch.valid && sample_ch.ready;
	assign out_free   = !out_valid_q || result_ch.ready;

	assign sample_ch.ready          = (uw.op == OP_ACCEPT);
	assign result_ch.valid          = out_valid_q;
	assign result_ch.timer_reload   = out_reload_q;
	assign result_ch.loop_frequency = out_freq_q;
	assign result_ch.phase_error    = out_err_q;

	// Pick the next step from the control word
	always_comb begin
		unique case (uw.cond)
			CND_NEXT:     step_d = step_q + step_t'(1);
			CND_WAIT_IN:  step_d = sample_acc ? step_q + step_t'(1) : step_q;
			CND_ZERO_SPD: step_d = (loop_speed_q == '0) ? uw.target : step_q + step_t'(1);
			CND_LOOP:     step_d = (cnt_q != '0) ? uw.target : step_q + step_t'(1);
			CND_WAIT_OUT: step_d = out_free ? uw.target : step_q;
			CND_JUMP:     step_d = uw.target;
			default:      step_d = STEP_ACCEPT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_ACCEPT;
		end else begin
			step_q <= step_d;
		end
	end

	// Alternating phase error of the incoming sample
	always_comb begin
		cur_x   = {sample_ch.grid_sample[SAMPLE_BITS-1], sample_ch.grid_sample};
		prev_x  = {prev_q[SAMPLE_BITS-1], prev_q};
		err_new = odd_q ? (cur_x - prev_x) : (prev_x - cur_x);
	end

	// Shared multiplier operands
	always_comb begin
		unique case (uw.op)
			OP_MUL_PS: begin
				mul_a = prod_q[MUL_A_BITS-1:0];
				mul_b = $signed({1'b0, loop_speed_q});
			end
			OP_MUL_IE: begin
				mul_a = {{(MUL_A_BITS-ERR_BITS){err_q[ERR_BITS-1]}}, err_q};
				mul_b = $signed({{(MUL_B_BITS-GAIN_BITS){1'b0}}, integ_gain_q});
			end
			default: begin
				mul_a = {{(MUL_A_BITS-ERR_BITS){err_q[ERR_BITS-1]}}, err_q};
				mul_b = $signed({{(MUL_B_BITS-GAIN_BITS){1'b0}}, prop_gain_q});
			end
		endcase
		product = mul_a * mul_b;
	end

	// Magnitude of the numerator and the divider hookup
	assign num_abs       = num_q[NUM_BITS-1] ? (NUM_BITS'(0) - num_q) : num_q;
	assign div_ctrl.load = (uw.op == OP_ABS);
	assign div_ctrl.step = (uw.op == OP_DIV);

	gpll_div u_div (
		.clk      (clk),
		.ctrl     (div_ctrl),
		.dividend (num_abs[MAG_BITS-1:0]),
		.divisor  ({loop_speed_q, {VOLT_FRAC_BITS{1'b0}}}),
		.quotient (quotient)
	);

	// Signed quotient minus the timer offset in one adder
	always_comb begin
		quot_x   = {{(NUM_BITS-MAG_BITS){1'b0}}, quotient};
		qoff_lhs = neg_q ? ~quot_x : quot_x;
		qoff_sub = neg_q ? TIMER_OFFSET_M1 : TIMER_OFFSET;
	end

	// Clamp the reload: low limit first, high limit last
	always_comb begin
		t_lo     = $signed({{(NUM_BITS-TIMER_BITS){1'b0}}, timer_min_q});
		t_hi     = $signed({{(NUM_BITS-TIMER_BITS){1'b0}}, timer_max_q});
		t_low_cl = (qoff_q < t_lo) ? t_lo : qoff_q;
		t_cl     = (t_low_cl > t_hi) ? t_hi : t_low_cl;
	end

	// Round the integral product to the nearest speed step, ties away from zero
	always_comb begin
		p_abs = prod_q[PROD_BITS-1] ? (MUL_A_BITS'(0) - prod_q[MUL_A_BITS-1:0])
			: prod_q[MUL_A_BITS-1:0];
		p_rnd = p_abs + ROUND_HALF;
		inc_x = inc_neg_q ? (SUM_BITS'(0) - SUM_BITS'(mag_q)) : SUM_BITS'(mag_q);
	end

	// Clamp the new loop speed: low limit first, high limit last
	always_comb begin
		f_lo     = $signed({{(SUM_BITS-FREQ_BITS){1'b0}}, freq_min_q});
		f_hi     = $signed({{(SUM_BITS-FREQ_BITS){1'b0}}, freq_max_q});
		f_low_cl = (sum_q < f_lo) ? f_lo : sum_q;
		f_cl     = (f_low_cl > f_hi) ? f_hi : f_low_cl;
	end

	// Datapath registers, one operation per step
	always_ff @(posedge clk) begin
		unique case (uw.op)
			OP_ACCEPT: begin
				if (sample_acc) begin
					err_q <= err_new;
				end
			end
			OP_MUL_PE, OP_MUL_PS, OP_MUL_IE: begin
				prod_q <= product;
			end
			OP_NUM: begin
				num_q  <= CLK_SCALED - prod_q;
				zero_q <= (loop_speed_q == '0);
			end
			OP_ABS: begin
				neg_q <= num_q[NUM_BITS-1];
			end
			OP_QOFF: begin
				qoff_q <= $signed(qoff_lhs - qoff_sub);
			end
			OP_TCLAMP: begin
				reload_q <= zero_q ? timer_max_q : t_cl[TIMER_BITS-1:0];
			end
			OP_ROUND: begin
				mag_q     <= p_rnd[MUL_A_BITS-1:VOLT_FRAC_BITS];
				inc_neg_q <= prod_q[PROD_BITS-1];
			end
			OP_SUM: begin
				sum_q <= $signed({{(SUM_BITS-FREQ_BITS){1'b0}}, loop_speed_q}) + inc_x;
			end
			default: begin
			end
		endcase
	end

	// Divider iteration count: load on setup, count down while dividing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (uw.op == OP_ABS) begin
			cnt_q <= DIV_CNT_BITS'(MAG_BITS - 1);
		end else if (uw.op == OP_DIV && cnt_q != '0) begin
			cnt_q <= cnt_q - DIV_CNT_BITS'(1);
		end
	end

	// Configuration registers, loop state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= RST_PROP_GAIN;
			integ_gain_q <= RST_INTEG_GAIN;
			freq_min_q   <= RST_FREQ_MIN;
			freq_max_q   <= RST_FREQ_MAX;
			timer_min_q  <= RST_TIMER_MIN;
			timer_max_q  <= RST_TIMER_MAX;
			loop_speed_q <= RST_START_FREQ;
			prev_q       <= '0;
			odd_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_idx_t'(cfg_index))
					CFG_START_FREQ: loop_speed_q <= cfg_data[FREQ_BITS-1:0];
					CFG_PROP_GAIN:  prop_gain_q  <= cfg_data[GAIN_BITS-1:0];
					CFG_INTEG_GAIN: integ_gain_q <= cfg_data[GAIN_BITS-1:0];
					CFG_FREQ_MIN:   freq_min_q   <= cfg_data[FREQ_BITS-1:0];
					CFG_FREQ_MAX:   freq_max_q   <= cfg_data[FREQ_BITS-1:0];
					CFG_TIMER_MIN:  timer_min_q  <= cfg_data[TIMER_BITS-1:0];
					CFG_TIMER_MAX:  timer_max_q  <= cfg_data[TIMER_BITS-1:0];
					default: begin
					end
				endcase
			end
			// Advance the sample history on acceptance
			if (sample_acc) begin
				prev_q <= sample_ch.grid_sample;
				odd_q  <= !odd_q;
			end
			// Hand the finished item to the result register, drop it once taken
			if (uw.op == OP_EMIT && out_free) begin
				out_valid_q  <= 1'b1;
				loop_speed_q <= f_cl[FREQ_BITS-1:0];
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (uw.op == OP_EMIT && out_free) begin
			out_reload_q <= reload_q;
			out_freq_q   <= f_cl[FREQ_BITS-1:0];
			out_err_q    <= err_q;
		end
	end

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		sample_acc |=> step_q == STEP_MUL_PE)
		else $error("accepted sample did not start the program");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(step_q == STEP_EMIT))
		else $error("result raised outside the emit step");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == STEP_DIV && cnt_q == '0) |=> step_q == STEP_QOFF)
		else $error("divider loop did not exit after its last iteration");
`endif

endmodule

>>> tb/tb_grid_pll_pi_timer_loop.sv
// Self-checking testbench for the grid PLL timer loop: stimulus, predictor and scoreboard.
`timescale 1ns / 1ps

module tb_grid_pll_pi_timer_loop;
	import gpll_pkg::*;

	localparam int     LIMIT_CYCLES = 400000;
	localparam int     DRAIN_CYCLES = 64;
	localparam longint SCALED_CLOCK = 64'd16000000 << 25;
	localparam longint RELOAD_OFFSET = 131070;
	localparam longint DEF_START_FREQ = 3276800;
	localparam longint DEF_PROP_GAIN  = 5000;
	localparam longint DEF_INTEG_GAIN = 6554;
	localparam longint DEF_FREQ_MIN   = 3080192;
	localparam longint DEF_FREQ_MAX   = 3473408;
	localparam longint DEF_TIMER_MIN  = 19871;
	localparam longint DEF_TIMER_MAX  = 39140;
	localparam longint FREQ_FULL  = 4194303;
	localparam longint TIMER_FULL = 65535;
	localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED = 3'd7;

	typedef struct packed {
		timer_t reload;
		freq_t  freq;
		error_t err;
	} loop_update_t;

	// Tracks the loop state and holds the updates still owed by the block
	class pll_loop_scoreboard;
		loop_update_t pending_updates[$];
		longint start_freq, prop_gain, integ_gain, freq_lo, freq_hi, timer_lo, timer_hi;
		longint last_sample, loop_speed;
		bit     odd_phase;
		int     failures;

		function new();
			start_freq  = DEF_START_FREQ;
			prop_gain   = DEF_PROP_GAIN;
			integ_gain  = DEF_INTEG_GAIN;
			freq_lo     = DEF_FREQ_MIN;
			freq_hi     = DEF_FREQ_MAX;
			timer_lo    = DEF_TIMER_MIN;
			timer_hi    = DEF_TIMER_MAX;
			last_sample = 0;
			odd_phase   = 1'b0;
			loop_speed  = start_freq;
			failures    = 0;
		endfunction

		function int pending();
			return pending_updates.size();
		endfunction

		function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
			case (idx)
				CFG_START_FREQ: begin
					start_freq = data;
					loop_speed = start_freq;
				end
				CFG_PROP_GAIN:  prop_gain  = data[GAIN_BITS-1:0];
				CFG_INTEG_GAIN: integ_gain = data[GAIN_BITS-1:0];
				CFG_FREQ_MIN:   freq_lo    = data;
				CFG_FREQ_MAX:   freq_hi    = data;
				CFG_TIMER_MIN:  timer_lo   = data[TIMER_BITS-1:0];
				CFG_TIMER_MAX:  timer_hi   = data[TIMER_BITS-1:0];
				default: ;
			endcase
		endfunction

		// Advance the loop by one accepted sample and queue the update it owes
		function void log_sample(sample_t smp);
			longint cur, err, spd, num, quo, reload, prod, mag, step, nxt;
			loop_update_t upd;
			cur = longint'(smp);
			err = odd_phase ? (cur - last_sample) : (last_sample - cur);
			spd = loop_speed;
			if (spd <= 0) begin
				reload = timer_hi;
			end else begin
				num = SCALED_CLOCK - prop_gain * err * spd;
				quo = num / (spd * 1024);
				reload = quo - RELOAD_OFFSET;
				if (reload < timer_lo) reload = timer_lo;
				if (reload > timer_hi) reload = timer_hi;
			end
			// Round the integral step to nearest, halves away from zero
			prod = integ_gain * err;
			mag = (prod < 0) ? -prod : prod;
			mag = (mag + 512) >>> 10;
			step = (prod < 0) ? -mag : mag;
			nxt = spd + step;
			if (nxt < freq_lo) nxt = freq_lo;
			if (nxt > freq_hi) nxt = freq_hi;
			loop_speed  = nxt;
			last_sample = cur;
			odd_phase   = !odd_phase;
			upd.reload = timer_t'(reload);
			upd.freq   = freq_t'(nxt);
			upd.err    = error_t'(err);
			pending_updates.push_back(upd);
		endfunction

		function void check_update(timer_t reload, freq_t freq, error_t err);
			loop_update_t want;
			if (pending_updates.size() == 0) begin
				$display("%0t: unexpected result: reload %0d freq %0d error %0d",
					$time, reload, freq, err);
				failures++;
				return;
			end
			want = pending_updates.pop_front();
			if (reload !== want.reload) begin
				$display("%0t: timer_reload expected %0d, actual %0d", $time, want.reload, reload);
				failures++;
			end
			if (freq !== want.freq) begin
				$display("%0t: loop_frequency expected %0d, actual %0d", $time, want.freq, freq);
				failures++;
			end
			if (err !== want.err) begin
				$display("%0t: phase_error expected %0d, actual %0d", $time, want.err, err);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic idle_en;
	int   stall_left = 0;
	int   cycle_count = 0;

	pll_loop_scoreboard sb;

	gpll_sample_if sample_bus ();
	gpll_result_if result_bus ();

	grid_pll_pi_timer_loop u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample_ch (sample_bus.sink),
		.result_ch (result_bus.source)
	);

	always #5 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Stall the result side in random bursts
	always @(posedge clk) begin
		if (idle_en && stall_left == 0 && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 15);
			result_bus.ready <= 1'b0;
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
			result_bus.ready <= 1'b0;
		end else begin
			stall_left <= 0;
			result_bus.ready <= 1'b1;
		end
	end

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready)
			sb.check_update(result_bus.timer_reload, result_bus.loop_frequency,
				result_bus.phase_error);
	end

	// Send one request, leaving valid high for a possible follow-up
	task automatic send_sample(sample_t smp);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			sample_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		sample_bus.valid       <= 1'b1;
		sample_bus.grid_sample <= smp;
		do @(posedge clk); while (!sample_bus.ready);
		sb.log_sample(smp);
	endtask

	// Hold off until every owed update has come back
	task automatic drain();
		sample_bus.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, longint data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_BITS'(data);
		@(posedge clk);
		sb.set_reg(idx, CFG_DATA_BITS'(data));
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(longint st, longint pg, longint ig, longint flo, longint fhi,
		longint tlo, longint thi);
		write_reg(CFG_PROP_GAIN, pg);
		write_reg(CFG_INTEG_GAIN, ig);
		write_reg(CFG_FREQ_MIN, flo);
		write_reg(CFG_FREQ_MAX, fhi);
		write_reg(CFG_TIMER_MIN, tlo);
		write_reg(CFG_TIMER_MAX, thi);
		write_reg(CFG_START_FREQ, st);
	endtask

	function automatic longint pick_value(longint top);
		case ($urandom_range(0, 3))
			0: return 0;
			1: return top;
			default: return longint'($urandom_range(0, int'(top)));
		endcase
	endfunction

	// Draw a loop setting: mostly near lock, sometimes anywhere in range
	task automatic randomize_config();
		longint st;
		if ($urandom_range(0, 3) == 0) begin
			write_all(pick_value(FREQ_FULL), pick_value(TIMER_FULL), pick_value(TIMER_FULL),
				pick_value(FREQ_FULL), pick_value(FREQ_FULL),
				pick_value(TIMER_FULL), pick_value(TIMER_FULL));
		end else begin
			st = $urandom_range(2600000, 3900000);
			write_all(st, $urandom_range(0, 20000), $urandom_range(0, 30000),
				st - $urandom_range(0, 300000), st + $urandom_range(0, 290000),
				$urandom_range(10000, 28000), $urandom_range(29000, 65535));
		end
	endtask

	// Mostly alternating grid waveforms with jitter, the rest raw noise
	task automatic run_phase(int count, int hold_at);
		int sent, run_len, amp, jit, pol, v;
		sent = 0;
		pol = 1;
		while (sent < count) begin
			run_len = $urandom_range(5, 25);
			if ($urandom_range(0, 9) < 7) begin
				amp = $urandom_range(0, 2047);
				jit = $urandom_range(0, 64);
				repeat (run_len) begin
					v = pol * amp + $urandom_range(0, 2 * jit) - jit;
					if (v > 2047) v = 2047;
					if (v < -2048) v = -2048;
					send_sample(sample_t'(v));
					pol = -pol;
					if ($urandom_range(0, 3) == 0)
						amp = amp + $urandom_range(0, 40) - 20;
					if (amp < 0) amp = 0;
					sent++;
					if (sent == hold_at) drain();
				end
			end else begin
				repeat (run_len) begin
					send_sample(sample_t'($urandom_range(0, 4095)));
					sent++;
					if (sent == hold_at) drain();
				end
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n                 <= 1'b0;
		cfg_wr_en              <= 1'b0;
		cfg_index              <= '0;
		cfg_data               <= '0;
		idle_en                <= 1'b0;
		sample_bus.valid       <= 1'b0;
		sample_bus.grid_sample <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full-scale steps on both phases at the reset setting
		send_sample(sample_t'(0));
		send_sample(sample_t'(2047));
		send_sample(sample_t'(-2048));
		send_sample(sample_t'(-2048));
		send_sample(sample_t'(2047));
		send_sample(sample_t'(2047));
		send_sample(sample_t'(-2048));
		send_sample(sample_t'(-1));
		send_sample(sample_t'(1));
		drain();

		// Unmapped register index must leave everything alone
		write_reg(CFG_UNMAPPED, FREQ_FULL);
		send_sample(sample_t'(300));
		drain();

		// Zero loop speed: reload falls back to the upper timer limit
		write_reg(CFG_INTEG_GAIN, 0);
		write_reg(CFG_FREQ_MIN, 0);
		write_reg(CFG_START_FREQ, 0);
		send_sample(sample_t'(-700));
		send_sample(sample_t'(900));
		drain();

		// Crossed limits and maximal gains
		write_all(FREQ_FULL, TIMER_FULL, TIMER_FULL, FREQ_FULL, 0, TIMER_FULL, 0);
		send_sample(sample_t'(2047));
		send_sample(sample_t'(-2048));
		send_sample(sample_t'(2047));
		drain();

		// Widest limits at top speed
		write_all(FREQ_FULL, TIMER_FULL, TIMER_FULL, 0, FREQ_FULL, 0, TIMER_FULL);
		send_sample(sample_t'(-2048));
		send_sample(sample_t'(2047));
		send_sample(sample_t'(0));
		drain();

		// Random phases; the last one runs at the reset setting with no idling
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 7)
				write_all(DEF_START_FREQ, DEF_PROP_GAIN, DEF_INTEG_GAIN, DEF_FREQ_MIN,
					DEF_FREQ_MAX, DEF_TIMER_MIN, DEF_TIMER_MAX);
			else
				randomize_config();
			idle_en <= (ph == 7) ? 1'b0 : ($urandom_range(0, 4) != 0);
			run_phase(60, (ph == 3) ? 30 : -1);
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> filelist.f
rtl/gpll_pkg.sv
rtl/gpll_if.sv
rtl/gpll_div.sv
rtl/grid_pll_pi_timer_loop.sv
tb/tb_grid_pll_pi_timer_loop.sv
